// ===== src/u8u16_pkg.sv =====
package u8u16_pkg;

	// Input beat: one UTF-8 byte or an end-of-string marker
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_beat_t;

	// Output beat: one UTF-16 unit or the end-of-string status
	typedef struct packed {
		logic [15:0] code_unit;
		logic        is_end;
		logic        end_status;
		logic        last_of_run;
	} out_beat_t;

	// Kind codes
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// End status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_EXHAUSTED = 1'b1;

	// Code point limits and surrogate bases
	localparam logic [31:0] BMP_MAX         = 32'h0000_FFFF;
	localparam logic [31:0] UNICODE_MAX     = 32'h0010_FFFF;
	localparam logic [15:0] REPLACEMENT     = 16'hFFFD;
	localparam logic [20:0] SUPPL_BASE      = 21'h01_0000;
	localparam logic [15:0] HIGH_SURR_BASE  = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE   = 16'hDC00;

	// Trailing-byte count from the lead byte
	function automatic logic [2:0] trail_count(input logic [7:0] b);
		logic [2:0] n;
		priority if (b < 8'hC0) n = 3'd0;
		else if (b < 8'hE0)     n = 3'd1;
		else if (b < 8'hF0)     n = 3'd2;
		else if (b < 8'hF8)     n = 3'd3;
		else if (b < 8'hFC)     n = 3'd4;
		else                    n = 3'd5;
		return n;
	endfunction

	// Offset removed after the last byte of a sequence
	function automatic logic [31:0] seq_offset(input logic [2:0] extra);
		logic [31:0] off;
		unique case (extra)
			3'd0:    off = 32'h0000_0000;
			3'd1:    off = 32'h0000_3080;
			3'd2:    off = 32'h000E_2080;
			3'd3:    off = 32'h03C8_2080;
			3'd4:    off = 32'hFA08_2080;
			3'd5:    off = 32'h8208_2080;
			default: off = 32'h0000_0000;
		endcase
		return off;
	endfunction

endpackage

// ===== src/utf8_to_utf16_decoder.sv =====
// Channel  | Direction | Signals                         | Beat
// ---------+-----------+---------------------------------+---------------------------
// in       | input     | in_valid, in_ready, in_data     | one UTF-8 byte or end mark
// out      | output    | out_valid, out_ready, out_data  | one UTF-16 unit or status
//
// A byte is decoded in the cycle it is accepted; its results sit in a
// two-entry output register and appear the next cycle.
// One input beat per cycle while out_ready is high; a surrogate pair holds
// off input while the second unit of the pair drains from the output register.
// in_ready stays high while the output register empties in the same cycle.
// arst_n clears the decode state and the output register valid bits at once.
module utf8_to_utf16_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  u8u16_pkg::in_beat_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output u8u16_pkg::out_beat_t out_data
);
	import u8u16_pkg::*;

	// Decode state
	logic [31:0] acc_q;
	logic [2:0]  left_q;
	logic [2:0]  extra_q;

	// Output register: slot0 is shown, slot1 holds the second unit of a pair
	out_beat_t slot0_q, slot1_q;
	logic      vld0_q, vld1_q;

	logic in_acc, out_acc;

	assign out_valid = vld0_q;
	assign out_data  = slot0_q;
	assign out_acc   = vld0_q && out_ready;
	assign in_ready  = !vld0_q || (out_ready && !vld1_q);
	assign in_acc    = in_valid && in_ready;

	// Next state and raw value
	logic [2:0]  lead_n;
	logic [31:0] shifted;
	logic [31:0] raw;
	logic [2:0]  emit_extra;
	logic        emit;
	logic [31:0] acc_n;
	logic [2:0]  left_n, extra_n, left_dec;

	always_comb begin
		lead_n     = trail_count(in_data.data_byte);
		shifted    = {acc_q[25:0], 6'd0} + {24'd0, in_data.data_byte};
		left_dec   = left_q - 3'd1;
		raw        = shifted;
		emit_extra = extra_q;
		emit       = 1'b0;
		acc_n      = acc_q;
		left_n     = left_q;
		extra_n    = extra_q;
		if (in_data.kind == KIND_END) begin
			acc_n   = '0;
			left_n  = '0;
			extra_n = '0;
		end else if (left_q == 3'd0) begin
			raw        = {24'd0, in_data.data_byte};
			emit_extra = 3'd0;
			emit       = (lead_n == 3'd0);
			acc_n      = {24'd0, in_data.data_byte};
			left_n     = lead_n;
			extra_n    = lead_n;
		end else begin
			emit   = (left_dec == 3'd0);
			left_n = left_dec;
			if (left_dec == 3'd0) begin
				acc_n   = '0;
				extra_n = '0;
			end else begin
				acc_n = shifted;
			end
		end
	end

	// Code point to UTF-16 units
	logic [31:0] cp;
	logic [19:0] suppl;
	out_beat_t   r0, r1;
	logic        two;

	always_comb begin
		cp    = raw - seq_offset(emit_extra);
		suppl = 20'(cp[20:0] - SUPPL_BASE);
		r0    = '{code_unit: '0, is_end: 1'b0, end_status: STATUS_OK, last_of_run: 1'b1};
		r1    = '{code_unit: '0, is_end: 1'b0, end_status: STATUS_OK, last_of_run: 1'b1};
		two   = 1'b0;
		if (in_data.kind == KIND_END) begin
			r0.is_end     = 1'b1;
			r0.end_status = (left_q != 3'd0) ? STATUS_EXHAUSTED : STATUS_OK;
		end else if (cp <= BMP_MAX) begin
			r0.code_unit = cp[15:0];
		end else if (cp > UNICODE_MAX) begin
			r0.code_unit = REPLACEMENT;
		end else begin
			two            = 1'b1;
			r0.code_unit   = HIGH_SURR_BASE + {6'd0, suppl[19:10]};
			r0.last_of_run = 1'b0;
			r1.code_unit   = LOW_SURR_BASE + {6'd0, suppl[9:0]};
		end
	end

	// Decode state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			left_q  <= '0;
			extra_q <= '0;
		end else if (in_acc) begin
			acc_q   <= acc_n;
			left_q  <= left_n;
			extra_q <= extra_n;
		end
	end

	// Output register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld0_q <= 1'b0;
			vld1_q <= 1'b0;
		end else if (in_acc) begin
			vld0_q <= (in_data.kind == KIND_END) || emit;
			vld1_q <= (in_data.kind == KIND_DATA) && emit && two;
		end else if (out_acc) begin
			vld0_q <= vld1_q;
			vld1_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (out_acc) begin
			slot0_q <= slot1_q;
		end
	end

	// Checks
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld1_q |-> vld0_q)
		else $error("second output slot valid without first");

	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		vld1_q |-> !slot0_q.last_of_run && !slot0_q.is_end)
		else $error("pending pair unit behind a final beat");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.is_end) |->
			(out_data.last_of_run && out_data.code_unit == 16'd0))
		else $error("end status beat malformed");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_data.kind == KIND_END) |=>
			(left_q == 3'd0 && acc_q == 32'd0 && extra_q == 3'd0))
		else $error("state not cleared after end of string");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q <= 3'd5) && (extra_q <= 3'd5))
		else $error("trailing count out of range");

endmodule
